/* design/arb_pkg.sv */
// Shared types and constants for the affine rectangle bounds block.
`timescale 1ns / 1ps
`default_nettype none

package arb_pkg;

	localparam int COORD_W = 24;
	localparam int COEF_W  = 32;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	localparam cfg_idx_t REG_COEF_AX  = 3'd0;
	localparam cfg_idx_t REG_COEF_AY  = 3'd1;
	localparam cfg_idx_t REG_COEF_BX  = 3'd2;
	localparam cfg_idx_t REG_COEF_BY  = 3'd3;
	localparam cfg_idx_t REG_OFFSET_X = 3'd4;
	localparam cfg_idx_t REG_OFFSET_Y = 3'd5;

	localparam coef_t COEF_ONE  = 32'sd65536;
	localparam coef_t COEF_ZERO = 32'sd0;

	localparam coord_t COORD_MAX = 24'sh7FFFFF;
	localparam coord_t COORD_MIN = 24'sh800000;

endpackage

`default_nettype wire

/* design/arb_ifs.sv */
// Valid/ready channel interfaces for rectangle beats in and bounding box beats out.
`timescale 1ns / 1ps
`default_nettype none

interface arb_in_if;
	import arb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t in_left;
	coord_t in_top;
	coord_t in_right;
	coord_t in_bottom;

	modport source (output valid, output in_left, output in_top, output in_right,
		output in_bottom, input ready);
	modport sink (input valid, input in_left, input in_top, input in_right,
		input in_bottom, output ready);
endinterface

interface arb_out_if;
	import arb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_left;
	coord_t out_top;
	coord_t out_right;
	coord_t out_bottom;

	modport source (output valid, output out_left, output out_top, output out_right,
		output out_bottom, input ready);
	modport sink (input valid, input out_left, input out_top, input out_right,
		input out_bottom, output ready);
endinterface

`default_nettype wire

/* design/affine_rect_bounds_core.sv */
// Top level: maps a rectangle through a Q16.16 affine matrix and returns its bounding box.
//
//   channel | direction | payload                                   | handshake
//   rect    | in        | in_left, in_top, in_right, in_bottom      | valid/ready
//   bbox    | out       | out_left, out_top, out_right, out_bottom  | valid/ready
//   cfg     | in        | cfg_index, cfg_data                       | cfg_we, no wait
//
// One rectangle enters per cycle unless the output stalls. The accepting edge loads
// the first of four register stages, and bbox.valid is driven by the fourth.
// The four stages are: eight 24x32 multipliers, min/max term selection, the three-input
// sum with the offset, and rounding with saturation into the output register.
// Reset clears all valid bits and loads the identity matrix.
// The whole pipeline holds while the output beat waits; rect.ready then falls.
`timescale 1ns / 1ps
`default_nettype none

module affine_rect_bounds_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire arb_pkg::cfg_idx_t cfg_index,
	input  wire arb_pkg::coef_t    cfg_data,
	arb_in_if.sink                 rect,
	arb_out_if.source              bbox
);
	import arb_pkg::*;

	localparam int PROD_W = COORD_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W + 1;
	localparam int SHR_W  = RND_W - 16;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	function automatic prod_t pmin(input prod_t a, input prod_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic prod_t pmax(input prod_t a, input prod_t b);
		return (a > b) ? a : b;
	endfunction

	// Half away from zero: negative values take a bias one short of one half.
	function automatic coord_t round_sat(input sum_t q);
		logic signed [RND_W-1:0] biased;
		logic signed [SHR_W-1:0] r;
		biased = RND_W'(q) + ((q < 0) ? RND_W'(32'sh7FFF) : RND_W'(32'sh8000));
		r = SHR_W'(biased >>> 16);
		if (r > SHR_W'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (r < SHR_W'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return r[COORD_W-1:0];
	endfunction

	// Configuration registers.
	coef_t coef_ax_q, coef_ay_q, coef_bx_q, coef_by_q, offset_x_q, offset_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_ax_q  <= COEF_ONE;
			coef_ay_q  <= COEF_ZERO;
			coef_bx_q  <= COEF_ZERO;
			coef_by_q  <= COEF_ONE;
			offset_x_q <= COEF_ZERO;
			offset_y_q <= COEF_ZERO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_AX:  coef_ax_q  <= cfg_data;
				REG_COEF_AY:  coef_ay_q  <= cfg_data;
				REG_COEF_BX:  coef_bx_q  <= cfg_data;
				REG_COEF_BY:  coef_by_q  <= cfg_data;
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// An axis-aligned positive scale keeps the stored corners in place.
	logic simple;
	assign simple = (coef_ax_q > 0) && (coef_by_q > 0) &&
		(coef_ay_q == COEF_ZERO) && (coef_bx_q == COEF_ZERO);

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4;

	assign advance    = !v_s4 || bbox.ready;
	assign rect.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= rect.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: products. Each mapped coordinate splits into an x term and a y term.
	prod_t lax_s1, rax_s1, tbx_s1, bbx_s1;
	prod_t lay_s1, ray_s1, tby_s1, bby_s1;
	logic  simple_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			lax_s1    <= rect.in_left   * coef_ax_q;
			rax_s1    <= rect.in_right  * coef_ax_q;
			tbx_s1    <= rect.in_top    * coef_bx_q;
			bbx_s1    <= rect.in_bottom * coef_bx_q;
			lay_s1    <= rect.in_left   * coef_ay_q;
			ray_s1    <= rect.in_right  * coef_ay_q;
			tby_s1    <= rect.in_top    * coef_by_q;
			bby_s1    <= rect.in_bottom * coef_by_q;
			simple_s1 <= simple;
		end
	end

	// Stage 2: the box over four corners is separable, so each edge takes the
	// min or max of its x term and of its y term independently; simple maps pass through.
	prod_t lx_a_s2, lx_b_s2, rx_a_s2, rx_b_s2;
	prod_t ty_a_s2, ty_b_s2, by_a_s2, by_b_s2;
	logic  simple_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			simple_s2 <= simple_s1;
			if (simple_s1) begin
				lx_a_s2 <= lax_s1;
				lx_b_s2 <= tbx_s1;
				rx_a_s2 <= rax_s1;
				rx_b_s2 <= bbx_s1;
				ty_a_s2 <= lay_s1;
				ty_b_s2 <= tby_s1;
				by_a_s2 <= ray_s1;
				by_b_s2 <= bby_s1;
			end else begin
				lx_a_s2 <= pmin(lax_s1, rax_s1);
				lx_b_s2 <= pmin(tbx_s1, bbx_s1);
				rx_a_s2 <= pmax(lax_s1, rax_s1);
				rx_b_s2 <= pmax(tbx_s1, bbx_s1);
				ty_a_s2 <= pmin(lay_s1, ray_s1);
				ty_b_s2 <= pmin(tby_s1, bby_s1);
				by_a_s2 <= pmax(lay_s1, ray_s1);
				by_b_s2 <= pmax(tby_s1, bby_s1);
			end
		end
	end

	// Stage 3: exact sums with the translation.
	sum_t left_s3, top_s3, right_s3, bottom_s3;
	logic simple_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			simple_s3 <= simple_s2;
			left_s3   <= SUM_W'(lx_a_s2) + SUM_W'(lx_b_s2) + SUM_W'(offset_x_q);
			right_s3  <= SUM_W'(rx_a_s2) + SUM_W'(rx_b_s2) + SUM_W'(offset_x_q);
			top_s3    <= SUM_W'(ty_a_s2) + SUM_W'(ty_b_s2) + SUM_W'(offset_y_q);
			bottom_s3 <= SUM_W'(by_a_s2) + SUM_W'(by_b_s2) + SUM_W'(offset_y_q);
		end
	end

	// Stage 4: rounding and saturation; this is the output register.
	coord_t left_s4, top_s4, right_s4, bottom_s4;
	logic   simple_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			simple_s4 <= simple_s3;
			left_s4   <= round_sat(left_s3);
			right_s4  <= round_sat(right_s3);
			top_s4    <= round_sat(top_s3);
			bottom_s4 <= round_sat(bottom_s3);
		end
	end

	assign bbox.valid      = v_s4;
	assign bbox.out_left   = left_s4;
	assign bbox.out_top    = top_s4;
	assign bbox.out_right  = right_s4;
	assign bbox.out_bottom = bottom_s4;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		bbox.valid && !bbox.ready |-> !rect.ready)
		else $error("input accepted while the output beat is stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rect.valid && rect.ready |=> v_s1)
		else $error("accepted beat did not reach the first stage");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !simple_s4 |-> (left_s4 <= right_s4) && (top_s4 <= bottom_s4))
		else $error("bounding box edges out of order");

endmodule

`default_nettype wire
